// ----- rtl/can_lock_frame_freshness_checker_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the CAN lock frame freshness checker
// Each macro builds one labelled, clocked assertion with an asynchronous
// reset disable.
// ----------------------------------------------------------------------------
`ifndef CAN_LOCK_FRAME_FRESHNESS_CHECKER_UNIT_ASSERT_SVH
`define CAN_LOCK_FRAME_FRESHNESS_CHECKER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLFC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CLFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/clfc_pkg.sv -----
// ----------------------------------------------------------------------------
// CAN lock frame freshness checker package
// Shared widths, codes, the queue entry type and field helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package clfc_pkg;

	localparam int IN_W       = 136;
	localparam int OUT_W      = 72;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 29;

	localparam logic [3:0] MAX_BYTES = 4'd8;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MATCH_ID    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MATCH_EXT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXP_LENGTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COUNTER_FLD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COMMAND_FLD = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SECURED_FLD = 3'd6;

	localparam logic [3:0] ST_DISABLED     = 4'd0;
	localparam logic [3:0] ST_IGNORED      = 4'd1;
	localparam logic [3:0] ST_PRIMED       = 4'd2;
	localparam logic [3:0] ST_NO_COMMAND   = 4'd3;
	localparam logic [3:0] ST_EVIDENCE     = 4'd4;
	localparam logic [3:0] ST_BAD_CONFIG   = 4'd5;
	localparam logic [3:0] ST_BAD_FRAME    = 4'd6;
	localparam logic [3:0] ST_DUPLICATE    = 4'd7;
	localparam logic [3:0] ST_OUT_OF_ORDER = 4'd8;
	localparam logic [3:0] ST_TIME_REGRESS = 4'd9;

	localparam logic [1:0] KIND_CLEAR  = 2'd0;
	localparam logic [1:0] KIND_REPORT = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;
	localparam logic [1:0] KIND_CHECK  = 2'd3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [QUEUE_CNT_W-1:0] QUEUE_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  status;
		logic [7:0]  raw;
		logic [3:0]  bits;
		logic        active;
		logic        secured;
		logic [31:0] stamp;
	} clfc_entry_t;

	function automatic logic [7:0] pick_byte(input logic [63:0] payload,
			input logic [2:0] idx);
		return payload[{idx, 3'b000} +: 8];
	endfunction

	function automatic logic field_match(input logic [18:0] field,
			input logic [63:0] payload, input logic [3:0] len);
		logic [7:0] b;
		b = pick_byte(payload, field[18:16]);
		return ({1'b0, field[18:16]} < len) &&
			((b & field[15:8]) == (field[7:0] & field[15:8]));
	endfunction

endpackage

`default_nettype wire

// ----- rtl/clfc_front.sv -----
// ----------------------------------------------------------------------------
// Front end
// Holds the configuration registers, accepts frames and classifies each one
// into a queue entry for the tracking back end.
// ----------------------------------------------------------------------------
`default_nettype none

module clfc_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output      logic                             cfg_ready,
	input  wire logic [clfc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [clfc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                             s_tvalid,
	output      logic                             s_tready,
	input  wire logic                             s_tuser,
	input  wire logic [clfc_pkg::IN_W-1:0]        s_tdata,
	input  wire logic                             q_full,
	output      logic                             q_push,
	output      clfc_pkg::clfc_entry_t            q_entry
);

	logic        enable_q;
	logic [28:0] match_id_q;
	logic        match_ext_q;
	logic [3:0]  exp_len_q;
	logic [10:0] counter_fld_q;
	logic [18:0] command_fld_q;
	logic [18:0] secured_fld_q;

	logic [28:0] ident;
	logic        fext;
	logic [3:0]  flen;
	logic [63:0] payload;
	logic [31:0] stamp;

	logic        id_fits;
	logic        cfg_ok;
	logic        frame_bad;
	logic [2:0]  cidx;
	logic [2:0]  lidx;
	logic [2:0]  sidx;
	logic [7:0]  cmask;
	logic [7:0]  lmask;
	logic [7:0]  smask;
	logic [7:0]  cbyte;
	logic [7:0]  raw;
	logic [3:0]  pos;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b0;
			match_id_q    <= '0;
			match_ext_q   <= 1'b0;
			exp_len_q     <= clfc_pkg::MAX_BYTES;
			counter_fld_q <= '0;
			command_fld_q <= '0;
			secured_fld_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				clfc_pkg::REG_ENABLE:      enable_q      <= cfg_data[0];
				clfc_pkg::REG_MATCH_ID:    match_id_q    <= cfg_data[28:0];
				clfc_pkg::REG_MATCH_EXT:   match_ext_q   <= cfg_data[0];
				clfc_pkg::REG_EXP_LENGTH:  exp_len_q     <= cfg_data[3:0];
				clfc_pkg::REG_COUNTER_FLD: counter_fld_q <= cfg_data[10:0];
				clfc_pkg::REG_COMMAND_FLD: command_fld_q <= cfg_data[18:0];
				clfc_pkg::REG_SECURED_FLD: secured_fld_q <= cfg_data[18:0];
				default: begin
				end
			endcase
		end
	end

	assign ident   = s_tdata[28:0];
	assign fext    = s_tdata[29];
	assign flen    = s_tdata[33:30];
	assign payload = s_tdata[97:34];
	assign stamp   = s_tdata[129:98];

	assign cidx  = counter_fld_q[10:8];
	assign cmask = counter_fld_q[7:0];
	assign lidx  = command_fld_q[18:16];
	assign lmask = command_fld_q[15:8];
	assign sidx  = secured_fld_q[18:16];
	assign smask = secured_fld_q[15:8];

	assign id_fits = match_ext_q || (match_id_q[28:11] == '0);
	assign cfg_ok  = id_fits && (exp_len_q != 4'd0) && (exp_len_q <= clfc_pkg::MAX_BYTES)
		&& ({1'b0, cidx} < exp_len_q) && (cmask != 8'd0)
		&& ({1'b0, lidx} < exp_len_q) && (lmask != 8'd0)
		&& ({1'b0, sidx} < exp_len_q) && (smask != 8'd0)
		&& ((lidx != cidx) || ((lmask & cmask) == 8'd0))
		&& ((sidx != cidx) || ((smask & cmask) == 8'd0))
		&& ((lidx != sidx) || ((lmask & smask) == 8'd0));

	assign frame_bad = (flen > clfc_pkg::MAX_BYTES) || (!fext && (ident[28:11] != '0));

	assign cbyte = ({1'b0, cidx} < flen) ? clfc_pkg::pick_byte(payload, cidx) : 8'd0;

	always_comb begin
		raw = 8'd0;
		pos = 4'd0;
		for (int b = 0; b < 8; b++) begin
			if (cmask[b]) begin
				raw[pos[2:0]] = cbyte[b];
				pos = pos + 4'd1;
			end
		end
	end

	always_comb begin
		q_entry.raw     = raw;
		q_entry.bits    = pos;
		q_entry.active  = clfc_pkg::field_match(command_fld_q, payload, flen);
		q_entry.secured = clfc_pkg::field_match(secured_fld_q, payload, flen);
		q_entry.stamp   = stamp;
		q_entry.kind    = clfc_pkg::KIND_CHECK;
		q_entry.status  = clfc_pkg::ST_DISABLED;
		if (s_tuser) begin
			q_entry.kind = clfc_pkg::KIND_CLEAR;
		end else if (!enable_q) begin
			q_entry.kind = clfc_pkg::KIND_REPORT;
		end else if (!cfg_ok) begin
			q_entry.kind   = clfc_pkg::KIND_REJECT;
			q_entry.status = clfc_pkg::ST_BAD_CONFIG;
		end else if (frame_bad) begin
			q_entry.kind   = clfc_pkg::KIND_REJECT;
			q_entry.status = clfc_pkg::ST_BAD_FRAME;
		end else if ((ident != match_id_q) || (fext != match_ext_q)) begin
			q_entry.kind   = clfc_pkg::KIND_REPORT;
			q_entry.status = clfc_pkg::ST_IGNORED;
		end else if (flen != exp_len_q) begin
			q_entry.kind   = clfc_pkg::KIND_REJECT;
			q_entry.status = clfc_pkg::ST_BAD_FRAME;
		end
	end

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

endmodule

`default_nettype wire

// ----- rtl/clfc_queue.sv -----
// ----------------------------------------------------------------------------
// Classified frame queue
// A short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "can_lock_frame_freshness_checker_unit_assert.svh"

module clfc_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire clfc_pkg::clfc_entry_t wr_entry,
	input  wire logic                  pop,
	output      clfc_pkg::clfc_entry_t rd_entry,
	output      logic                  full,
	output      logic                  empty
);

	clfc_pkg::clfc_entry_t slot_q [clfc_pkg::QUEUE_DEPTH];

	logic [clfc_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [clfc_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [clfc_pkg::QUEUE_CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign rd_entry = slot_q[rd_ptr_q];
	assign full     = (count_q == clfc_pkg::QUEUE_FULL);
	assign empty    = (count_q == '0);

	`CLFC_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= clfc_pkg::QUEUE_FULL, "queue count beyond depth")
	`CLFC_ASSERT_SAME(a_no_overflow, clk, arst_n, push, count_q != clfc_pkg::QUEUE_FULL, "push into full queue")
	`CLFC_ASSERT_SAME(a_no_underflow, clk, arst_n, pop, count_q != '0, "pop from empty queue")

endmodule

`default_nettype wire

// ----- rtl/clfc_back.sv -----
// ----------------------------------------------------------------------------
// Back end
// Keeps the tracking state, runs the timestamp and counter checks on each
// classified frame and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "can_lock_frame_freshness_checker_unit_assert.svh"

module clfc_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       q_empty,
	input  wire clfc_pkg::clfc_entry_t      q_entry,
	output      logic                       q_pop,
	output      logic                       m_tvalid,
	input  wire logic                       m_tready,
	output      logic [clfc_pkg::OUT_W-1:0] m_tdata
);

	logic        primed_q;
	logic [31:0] prior_stamp_q;
	logic [7:0]  prior_counter_q;
	logic        prior_active_q;
	logic [31:0] ext_seq_q;

	logic        out_valid_q;
	logic [3:0]  out_status_q;
	logic [31:0] out_seq_q;
	logic [31:0] out_stamp_q;
	logic        out_sec_q;

	logic        take;
	logic        res_load;
	logic        res_clear;
	logic        res_advance;
	logic        res_prime;
	logic [3:0]  res_status;
	logic        res_fields;
	logic [31:0] stamp_diff;
	logic        regress;
	logic [7:0]  cmask;
	logic [7:0]  cnt_step;
	logic        far;
	logic [31:0] new_seq;

	assign take  = !q_empty && (!out_valid_q || m_tready);
	assign q_pop = take;

	assign stamp_diff = q_entry.stamp - prior_stamp_q;
	assign regress    = primed_q && (q_entry.stamp != prior_stamp_q) && stamp_diff[31];
	assign cmask      = 8'((9'd1 << q_entry.bits) - 9'd1);
	assign cnt_step   = (q_entry.raw - prior_counter_q) & cmask;
	assign far        = cnt_step[3'(q_entry.bits - 4'd1)];
	assign new_seq    = ext_seq_q + {24'd0, cnt_step};

	always_comb begin
		res_load    = 1'b1;
		res_clear   = 1'b0;
		res_advance = 1'b0;
		res_prime   = 1'b0;
		res_fields  = 1'b0;
		res_status  = q_entry.status;
		case (q_entry.kind)
			clfc_pkg::KIND_CLEAR: begin
				res_load  = 1'b0;
				res_clear = 1'b1;
			end
			clfc_pkg::KIND_REPORT: begin
			end
			clfc_pkg::KIND_REJECT: begin
				res_clear = 1'b1;
			end
			clfc_pkg::KIND_CHECK: begin
				if (regress) begin
					res_status = clfc_pkg::ST_TIME_REGRESS;
					res_clear  = 1'b1;
				end else if (!primed_q) begin
					res_status = clfc_pkg::ST_PRIMED;
					res_prime  = 1'b1;
				end else if (cnt_step == 8'd0) begin
					res_status = clfc_pkg::ST_DUPLICATE;
					res_clear  = 1'b1;
				end else if (far) begin
					res_status = clfc_pkg::ST_OUT_OF_ORDER;
					res_clear  = 1'b1;
				end else begin
					res_advance = 1'b1;
					if (q_entry.active && !prior_active_q) begin
						res_status = clfc_pkg::ST_EVIDENCE;
						res_fields = 1'b1;
					end else begin
						res_status = clfc_pkg::ST_NO_COMMAND;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q        <= 1'b0;
			prior_stamp_q   <= '0;
			prior_counter_q <= '0;
			prior_active_q  <= 1'b0;
			ext_seq_q       <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (take) begin
				out_valid_q <= res_load;
				if (res_clear) begin
					primed_q        <= 1'b0;
					prior_stamp_q   <= '0;
					prior_counter_q <= '0;
					prior_active_q  <= 1'b0;
					ext_seq_q       <= '0;
				end else if (res_prime || res_advance) begin
					primed_q        <= 1'b1;
					prior_stamp_q   <= q_entry.stamp;
					prior_counter_q <= q_entry.raw;
					prior_active_q  <= q_entry.active;
					if (res_advance) begin
						ext_seq_q <= new_seq;
					end
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && res_load) begin
			out_status_q <= res_status;
			out_seq_q    <= res_fields ? new_seq : 32'd0;
			out_stamp_q  <= res_fields ? q_entry.stamp : 32'd0;
			out_sec_q    <= res_fields && q_entry.secured;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_sec_q, out_stamp_q, out_seq_q, out_status_q};

	`CLFC_ASSERT_SAME(a_quiet_fields, clk, arst_n, out_valid_q && (out_status_q != clfc_pkg::ST_EVIDENCE), (out_seq_q == '0) && (out_stamp_q == '0) && !out_sec_q, "fields set on a non-evidence result")
	`CLFC_ASSERT_NEXT(a_reject_clears, clk, arst_n, take && res_clear, !primed_q && (ext_seq_q == '0), "tracking kept after a rejection")
	`CLFC_ASSERT_SAME(a_evidence_primed, clk, arst_n, out_valid_q && (out_status_q == clfc_pkg::ST_EVIDENCE), primed_q, "evidence held without primed tracking")

endmodule

`default_nettype wire

// ----- rtl/can_lock_frame_freshness_checker_unit.sv -----
// An accepted frame is written into a queue slot; the back end takes it into the output register once that is free.
// Throughput: one frame per cycle while the queue is not full and the result side accepts results.
// A clear request takes one queue slot and produces no result.
// Reset clears the configuration to its defaults, the tracking state, the queue and the output valid.
// ----------------------------------------------------------------------------
// CAN lock frame freshness checker
// Filters CAN frames, checks timestamp and rolling counter freshness and
// reports rising lock commands as evidence.
// ----------------------------------------------------------------------------
`default_nettype none

module can_lock_frame_freshness_checker_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output      logic                             cfg_ready,
	input  wire logic [clfc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [clfc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                             s_tvalid,
	output      logic                             s_tready,
	// clear request
	input  wire logic                             s_tuser,
	// frame_ident, frame_is_extended, frame_length, frame_payload, stamp_ms
	input  wire logic [clfc_pkg::IN_W-1:0]        s_tdata,
	output      logic                             m_tvalid,
	input  wire logic                             m_tready,
	// status, sequence_out, stamp_out, vehicle_secured
	output      logic [clfc_pkg::OUT_W-1:0]       m_tdata
);

	clfc_pkg::clfc_entry_t wr_entry;
	clfc_pkg::clfc_entry_t rd_entry;
	logic                  q_push;
	logic                  q_pop;
	logic                  q_full;
	logic                  q_empty;

	clfc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (wr_entry)
	);

	clfc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (wr_entry),
		.pop      (q_pop),
		.rd_entry (rd_entry),
		.full     (q_full),
		.empty    (q_empty)
	);

	clfc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_entry  (rd_entry),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

// ----- dv/can_lock_frame_freshness_checker_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Testbench for the CAN lock frame freshness checker
// Frames are queued by a stimulus process and offered by a clocked driver with
// random gaps, while the result side stalls at random and once holds off for a
// long stretch. A monitor predicts each accepted request from its own copy of
// the configuration and tracking state, and compares every result with the
// oldest prediction. Directed frames come first, followed by random phases.
// ----------------------------------------------------------------------------
`default_nettype none

module can_lock_frame_freshness_checker_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_AFTER  = 400;
	localparam int HOLD_CYCLES = 250;

	typedef struct packed {
		logic        flush;
		logic [28:0] ident;
		logic        ext;
		logic [3:0]  len;
		logic [63:0] payload;
		logic [31:0] stamp;
	} frame_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [31:0] seq;
		logic [31:0] stamp;
		logic        secured;
	} verdict_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [clfc_pkg::CFG_IDX_W-1:0]  cfg_index = clfc_pkg::REG_ENABLE;
	logic [clfc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic                            s_tuser = 1'b0;
	logic [clfc_pkg::IN_W-1:0]       s_tdata = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [clfc_pkg::OUT_W-1:0]      m_tdata;

	can_lock_frame_freshness_checker_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// Register copy as seen by the block.
	logic        c_en = 1'b0;
	logic [28:0] c_mid = '0;
	logic        c_mext = 1'b0;
	logic [3:0]  c_elen = 4'd8;
	logic [10:0] c_cfld = '0;
	logic [18:0] c_kfld = '0;
	logic [18:0] c_sfld = '0;

	// Tracking state of the freshness check.
	bit          trk_primed = 1'b0;
	logic [31:0] trk_stamp = '0;
	logic [7:0]  trk_cnt = '0;
	bit          trk_act = 1'b0;
	logic [31:0] trk_seq = '0;

	frame_t      frame_q[$];
	verdict_t    verdict_q[$];
	int unsigned pushed_items = 0;
	int unsigned accepted_items = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	bit          in_taken = 1'b0;
	bit          cfg_taken = 1'b0;

	int unsigned tx_gap = 0;
	int unsigned rx_wait = 0;
	bit          tx_calm = 1'b0;
	bit          rx_calm = 1'b0;
	bit          rx_hold = 1'b0;

	// Generator view of the rolling counter and the clock of the sender.
	int unsigned g_cnt = 0;
	logic [31:0] g_stamp = '0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic bit cfg_ok(logic [28:0] mid, logic mext, logic [3:0] elen,
			logic [10:0] cf, logic [18:0] kf, logic [18:0] sf);
		bit ok;
		ok = (mid <= (mext ? 29'h1FFFFFFF : 29'h7FF)) && elen != 0 &&
			elen <= clfc_pkg::MAX_BYTES;
		ok = ok && ({1'b0, cf[10:8]} < elen) && cf[7:0] != 0;
		ok = ok && ({1'b0, kf[18:16]} < elen) && kf[15:8] != 0;
		ok = ok && ({1'b0, sf[18:16]} < elen) && sf[15:8] != 0;
		ok = ok && (kf[18:16] != cf[10:8] || (kf[15:8] & cf[7:0]) == 0);
		ok = ok && (sf[18:16] != cf[10:8] || (sf[15:8] & cf[7:0]) == 0);
		ok = ok && (kf[18:16] != sf[18:16] || (kf[15:8] & sf[15:8]) == 0);
		return ok;
	endfunction

	function automatic bit byte_hit(logic [18:0] fld, logic [63:0] payload, logic [3:0] len);
		logic [7:0] oct;
		oct = 8'(payload >> (fld[18:16] * 8));
		if ({1'b0, fld[18:16]} >= len)
			return 1'b0;
		return (oct & fld[15:8]) == (fld[7:0] & fld[15:8]);
	endfunction

	task automatic forget_tracking();
		trk_primed = 1'b0;
		trk_stamp = '0;
		trk_cnt = '0;
		trk_act = 1'b0;
		trk_seq = '0;
	endtask

	task automatic apply_config(logic [clfc_pkg::CFG_IDX_W-1:0] idx,
			logic [clfc_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			clfc_pkg::REG_ENABLE:      c_en = data[0];
			clfc_pkg::REG_MATCH_ID:    c_mid = data[28:0];
			clfc_pkg::REG_MATCH_EXT:   c_mext = data[0];
			clfc_pkg::REG_EXP_LENGTH:  c_elen = data[3:0];
			clfc_pkg::REG_COUNTER_FLD: c_cfld = data[10:0];
			clfc_pkg::REG_COMMAND_FLD: c_kfld = data[18:0];
			clfc_pkg::REG_SECURED_FLD: c_sfld = data[18:0];
			default: ;
		endcase
	endtask

	task automatic judge_frame(input frame_t f, output bit has, output verdict_t v);
		logic [7:0]  oct;
		logic [7:0]  raw;
		int unsigned nb;
		int unsigned modulus;
		int unsigned gap;
		bit          act;
		bit          reject;
		has = 1'b1;
		v = '0;
		reject = 1'b0;
		if (f.flush) begin
			forget_tracking();
			has = 1'b0;
		end else if (!c_en) begin
			v.status = clfc_pkg::ST_DISABLED;
		end else if (!cfg_ok(c_mid, c_mext, c_elen, c_cfld, c_kfld, c_sfld)) begin
			v.status = clfc_pkg::ST_BAD_CONFIG;
			reject = 1'b1;
		end else if (f.len > clfc_pkg::MAX_BYTES ||
				f.ident > (f.ext ? 29'h1FFFFFFF : 29'h7FF)) begin
			v.status = clfc_pkg::ST_BAD_FRAME;
			reject = 1'b1;
		end else if (f.ident != c_mid || f.ext != c_mext) begin
			v.status = clfc_pkg::ST_IGNORED;
		end else if (f.len != c_elen) begin
			v.status = clfc_pkg::ST_BAD_FRAME;
			reject = 1'b1;
		end else if (trk_primed && f.stamp != trk_stamp &&
				32'(f.stamp - trk_stamp) >= 32'h80000000) begin
			v.status = clfc_pkg::ST_TIME_REGRESS;
			reject = 1'b1;
		end else begin
			raw = '0;
			nb = 0;
			oct = 8'(f.payload >> (c_cfld[10:8] * 8));
			for (int b = 0; b < 8; b++) begin
				if (c_cfld[b]) begin
					if ({1'b0, c_cfld[10:8]} < f.len && oct[b])
						raw[nb] = 1'b1;
					nb++;
				end
			end
			act = byte_hit(c_kfld, f.payload, f.len);
			if (!trk_primed) begin
				trk_stamp = f.stamp;
				trk_cnt = raw;
				trk_act = act;
				trk_primed = 1'b1;
				v.status = clfc_pkg::ST_PRIMED;
			end else begin
				modulus = 1 << nb;
				gap = (raw + modulus - trk_cnt) & (modulus - 1);
				if (gap == 0) begin
					v.status = clfc_pkg::ST_DUPLICATE;
					reject = 1'b1;
				end else if (gap >= modulus / 2) begin
					v.status = clfc_pkg::ST_OUT_OF_ORDER;
					reject = 1'b1;
				end else begin
					trk_stamp = f.stamp;
					trk_cnt = raw;
					trk_seq = trk_seq + gap;
					if (act && !trk_act) begin
						v.status = clfc_pkg::ST_EVIDENCE;
						v.seq = trk_seq;
						v.stamp = f.stamp;
						v.secured = byte_hit(c_sfld, f.payload, f.len);
					end else begin
						v.status = clfc_pkg::ST_NO_COMMAND;
					end
					trk_act = act;
				end
			end
		end
		if (reject)
			forget_tracking();
	endtask

	always @(posedge clk) begin : watch_ports
		frame_t   f;
		verdict_t v;
		verdict_t got;
		bit       has;
		in_taken = s_tvalid && s_tready;
		cfg_taken = cfg_valid && cfg_ready;
		if (arst_n) begin
			if (cfg_taken)
				apply_config(cfg_index, cfg_data);
			if (in_taken) begin
				accepted_items++;
				f.flush = s_tuser;
				{f.stamp, f.payload, f.len, f.ext, f.ident} = s_tdata[129:0];
				judge_frame(f, has, v);
				if (has)
					verdict_q.push_back(v);
			end
			if (m_tvalid && m_tready) begin
				got.status = m_tdata[3:0];
				got.seq = m_tdata[35:4];
				got.stamp = m_tdata[67:36];
				got.secured = m_tdata[68];
				if (verdict_q.size() == 0) begin
					mismatches++;
					$display("%0t: result with none expected: status %0d seq %h stamp %h secured %b",
						$realtime, got.status, got.seq, got.stamp, got.secured);
				end else begin
					v = verdict_q.pop_front();
					if (got.status !== v.status || got.seq !== v.seq ||
							got.stamp !== v.stamp || got.secured !== v.secured) begin
						mismatches++;
						$display("%0t: expected status %0d seq %h stamp %h secured %b, got status %0d seq %h stamp %h secured %b",
							$realtime, v.status, v.seq, v.stamp, v.secured,
							got.status, got.seq, got.stamp, got.secured);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic int unsigned draw_pause(bit calm);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	always @(negedge clk) begin : drive_requests
		frame_t nf;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !in_taken) begin
			// The current request is still waiting for the block.
		end else if (tx_gap > 0) begin
			tx_gap--;
			s_tvalid <= 1'b0;
		end else if (frame_q.size() > 0) begin
			nf = frame_q.pop_front();
			s_tvalid <= 1'b1;
			s_tuser <= nf.flush;
			s_tdata <= {6'b0, nf.stamp, nf.payload, nf.len, nf.ext, nf.ident};
			tx_gap = draw_pause(tx_calm);
		end else begin
			s_tvalid <= 1'b0;
		end
		if ($urandom_range(0, 119) == 0)
			tx_calm = !tx_calm;
	end

	always @(negedge clk) begin
		if (!arst_n || rx_hold) begin
			m_tready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			rx_wait = draw_pause(rx_calm);
		end
		if ($urandom_range(0, 149) == 0)
			rx_calm = !rx_calm;
	end

	// A long hold-off on the result side so that the block backs up into its input.
	initial begin
		wait (accepted_items >= HOLD_AFTER);
		@(posedge clk);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold = 1'b0;
	end

	task automatic cfg_write(logic [clfc_pkg::CFG_IDX_W-1:0] idx,
			logic [clfc_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(negedge clk);
		while (!cfg_taken);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all(bit en, logic [28:0] mid, logic mext, logic [3:0] elen,
			logic [10:0] cf, logic [18:0] kf, logic [18:0] sf);
		cfg_write(clfc_pkg::REG_ENABLE, clfc_pkg::CFG_DATA_W'(en));
		cfg_write(clfc_pkg::REG_MATCH_ID, clfc_pkg::CFG_DATA_W'(mid));
		cfg_write(clfc_pkg::REG_MATCH_EXT, clfc_pkg::CFG_DATA_W'(mext));
		cfg_write(clfc_pkg::REG_EXP_LENGTH, clfc_pkg::CFG_DATA_W'(elen));
		cfg_write(clfc_pkg::REG_COUNTER_FLD, clfc_pkg::CFG_DATA_W'(cf));
		cfg_write(clfc_pkg::REG_COMMAND_FLD, clfc_pkg::CFG_DATA_W'(kf));
		cfg_write(clfc_pkg::REG_SECURED_FLD, clfc_pkg::CFG_DATA_W'(sf));
	endtask

	task automatic settle();
		while (accepted_items != pushed_items || verdict_q.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic push_item(frame_t f);
		frame_q.push_back(f);
		pushed_items++;
	endtask

	function automatic logic [63:0] mark(logic [63:0] p, logic [18:0] fld, bit hit);
		logic [7:0] oct;
		oct = p[{fld[18:16], 3'b000} +: 8];
		oct = (oct & ~fld[15:8]) | ((hit ? fld[7:0] : ~fld[7:0]) & fld[15:8]);
		p[{fld[18:16], 3'b000} +: 8] = oct;
		return p;
	endfunction

	// A frame that passes the filters, with the rolling counter moved on by adv.
	task automatic push_flow(int unsigned adv, logic [31:0] dt, bit act, bit sec,
			logic [63:0] base);
		frame_t     f;
		logic [7:0] oct;
		int         k;
		g_cnt += adv;
		g_stamp += dt;
		base = mark(base, c_sfld, sec);
		base = mark(base, c_kfld, act);
		oct = base[{c_cfld[10:8], 3'b000} +: 8];
		k = 0;
		for (int b = 0; b < 8; b++) begin
			if (c_cfld[b]) begin
				oct[b] = g_cnt[k];
				k++;
			end
		end
		base[{c_cfld[10:8], 3'b000} +: 8] = oct;
		f = '{flush: 1'b0, ident: c_mid, ext: c_mext, len: c_elen, payload: base,
			stamp: g_stamp};
		push_item(f);
	endtask

	task automatic rand_item();
		frame_t      f;
		int unsigned r;
		int unsigned s;
		int unsigned half;
		int unsigned adv;
		logic [31:0] dt;
		r = $urandom_range(0, 99);
		if (r < 72) begin
			half = (1 << $countones(c_cfld[7:0])) / 2;
			s = $urandom_range(0, 19);
			if (s < 17)
				adv = (half > 1) ? $urandom_range(1, half - 1) : 1;
			else if (s == 17)
				adv = 0;
			else
				adv = $urandom_range(0, 255);
			s = $urandom_range(0, 19);
			if (s < 14)
				dt = $urandom_range(1, 40);
			else if (s < 17)
				dt = '0;
			else
				dt = $urandom;
			push_flow(adv, dt, $urandom_range(0, 1), $urandom_range(0, 1),
				{$urandom, $urandom});
		end else begin
			f.flush = (r < 78);
			f.ext = $urandom_range(0, 1);
			s = $urandom_range(0, 3);
			if (s == 0)
				f.ident = c_mid;
			else if (s == 1)
				f.ident = 29'($urandom_range(0, 2047));
			else
				f.ident = 29'($urandom);
			f.len = $urandom_range(0, 1) ? c_elen : 4'($urandom_range(0, 15));
			f.payload = {$urandom, $urandom};
			f.stamp = $urandom_range(0, 1) ? 32'(g_stamp + $urandom_range(0, 20)) : $urandom;
			push_item(f);
		end
	endtask

	task automatic rand_config(bit want_valid, bit en);
		logic [28:0] mid;
		logic        mext;
		logic [3:0]  elen;
		logic [10:0] cf;
		logic [18:0] kf;
		logic [18:0] sf;
		do begin
			elen = $urandom_range(1, 8);
			mext = $urandom_range(0, 1);
			mid = mext ? 29'($urandom) : 29'($urandom_range(0, 2047));
			cf = {3'($urandom_range(0, elen - 1)), 8'($urandom_range(1, 255))};
			kf = {3'($urandom_range(0, elen - 1)), 8'($urandom), 8'($urandom)};
			sf = {3'($urandom_range(0, elen - 1)), 8'($urandom), 8'($urandom)};
			if (!want_valid) begin
				elen = $urandom_range(0, 8);
				mid = 29'($urandom);
			end
		end while (want_valid && !(cfg_ok(mid, mext, elen, cf, kf, sf) &&
				$countones(cf[7:0]) >= 2));
		write_all(en, mid, mext, elen, cf, kf, sf);
	endtask

	initial begin : stimulus
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Block still disabled after reset.
		g_stamp = 32'd100;
		push_flow(1, 5, 1'b0, 1'b0, {$urandom, $urandom});
		settle();

		write_all(1'b1, 29'h123, 1'b0, 4'd8, {3'd0, 8'h0F}, {3'd1, 8'hFF, 8'h5A},
			{3'd2, 8'h01, 8'h01});
		g_cnt = 5;
		g_stamp = 32'd1000;
		push_flow(0, 0, 1'b0, 1'b1, {$urandom, $urandom});
		push_flow(1, 10, 1'b0, 1'b1, {$urandom, $urandom});
		// Equal stamp is accepted, and the command rises.
		push_flow(1, 0, 1'b1, 1'b1, {$urandom, $urandom});
		push_flow(1, 5, 1'b1, 1'b0, {$urandom, $urandom});
		push_flow(0, 5, 1'b0, 1'b0, {$urandom, $urandom});
		push_flow(3, 5, 1'b0, 1'b0, {$urandom, $urandom});
		// Half the counter range away is out of order.
		push_flow(8, 5, 1'b1, 1'b0, {$urandom, $urandom});
		push_flow(1, 5, 1'b0, 1'b0, {$urandom, $urandom});
		push_flow(1, 32'hFFFFFFFF, 1'b0, 1'b0, {$urandom, $urandom});
		g_stamp = 32'hFFFFFFF0;
		push_flow(1, 0, 1'b0, 1'b0, 64'h0);
		// Stamp wraps through zero while the command rises.
		push_flow(7, 32'h20, 1'b1, 1'b1, 64'hFFFFFFFFFFFFFFFF);
		push_flow(1, 32'h7FFFFFFF, 1'b0, 1'b0, {$urandom, $urandom});
		push_flow(1, 32'h80000000, 1'b0, 1'b0, {$urandom, $urandom});
		push_item('{flush: 1'b0, ident: 29'h124, ext: 1'b0, len: 4'd8,
			payload: 64'h0, stamp: g_stamp});
		push_item('{flush: 1'b0, ident: 29'h123, ext: 1'b1, len: 4'd8,
			payload: 64'h0, stamp: g_stamp});
		push_item('{flush: 1'b0, ident: 29'h123, ext: 1'b0, len: 4'd9,
			payload: 64'h0, stamp: g_stamp});
		push_item('{flush: 1'b0, ident: 29'h123, ext: 1'b0, len: 4'd7,
			payload: 64'h0, stamp: g_stamp});
		push_item('{flush: 1'b0, ident: 29'h800, ext: 1'b0, len: 4'd8,
			payload: 64'h0, stamp: g_stamp});
		push_flow(1, 1, 1'b0, 1'b0, {$urandom, $urandom});
		push_item('{flush: 1'b1, ident: 29'h1FFFFFFF, ext: 1'b1, len: 4'd15,
			payload: 64'hFFFFFFFFFFFFFFFF, stamp: 32'hFFFFFFFF});
		push_flow(1, 1, 1'b1, 1'b1, {$urandom, $urandom});
		settle();

		// Widest identifier and a one-byte frame with every field in byte 0.
		write_all(1'b1, 29'h1FFFFFFF, 1'b1, 4'd1, {3'd0, 8'hF0}, {3'd0, 8'h0C, 8'hFF},
			{3'd0, 8'h03, 8'h00});
		push_flow(0, 0, 1'b0, 1'b1, {$urandom, $urandom});
		push_flow(5, 1, 1'b1, 1'b1, {$urandom, $urandom});
		push_flow(15, 1, 1'b0, 1'b0, {$urandom, $urandom});
		settle();

		cfg_write(clfc_pkg::REG_EXP_LENGTH, clfc_pkg::CFG_DATA_W'(0));
		push_flow(1, 1, 1'b0, 1'b0, {$urandom, $urandom});
		settle();
		write_all(1'b1, 29'h7FF, 1'b0, 4'd8, 11'h7FF, 19'h7FFFF, 19'h7FFFF);
		push_flow(1, 1, 1'b0, 1'b0, {$urandom, $urandom});
		settle();
		cfg_write(clfc_pkg::REG_COUNTER_FLD, clfc_pkg::CFG_DATA_W'(0));
		cfg_write(clfc_pkg::REG_COMMAND_FLD, clfc_pkg::CFG_DATA_W'({3'd1, 8'hFF, 8'h01}));
		cfg_write(clfc_pkg::REG_SECURED_FLD, clfc_pkg::CFG_DATA_W'({3'd2, 8'hFF, 8'h00}));
		push_flow(1, 1, 1'b0, 1'b0, {$urandom, $urandom});
		settle();

		for (int p = 0; p < 7; p++) begin
			rand_config(p != 4, p != 5);
			g_cnt = $urandom;
			g_stamp = $urandom;
			repeat (150) rand_item();
			settle();
		end

		repeat (20) @(negedge clk);
		if (mismatches == 0 && verdict_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

`default_nettype wire
